// ----- design/cia_pkg.sv -----
// shared types, codes and helpers for the checked integer alu
package cia_pkg;

    localparam int DATA_W     = 32;
    localparam int DIV_STAGES = DATA_W;
    localparam int DLY_STAGES = DIV_STAGES - 1;
    // edges from a sampled start to the sampled done strobe
    localparam int RSP_LAT    = DIV_STAGES + 3;

    typedef enum logic [4:0] {
        OP_ADD   = 5'd0,
        OP_SUB   = 5'd1,
        OP_MUL   = 5'd2,
        OP_DIV   = 5'd3,
        OP_MOD   = 5'd4,
        OP_XOR   = 5'd5,
        OP_AND   = 5'd6,
        OP_OR    = 5'd7,
        OP_SHL   = 5'd8,
        OP_SHR   = 5'd9,
        OP_EQ    = 5'd10,
        OP_NE    = 5'd11,
        OP_LT    = 5'd12,
        OP_LE    = 5'd13,
        OP_GT    = 5'd14,
        OP_GE    = 5'd15,
        OP_PLUS  = 5'd16,
        OP_NEG   = 5'd17,
        OP_NOT   = 5'd18,
        OP_COMPL = 5'd19
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVF      = 2'd1,
        ST_UDF      = 2'd2,
        ST_DIV_ZERO = 2'd3
    } t_status;

    typedef enum logic {
        CFG_TRUE  = 1'b0,
        CFG_FALSE = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [DATA_W-1:0] res;
        t_status           st;
    } t_chk;

    // range check of a 33-bit exact result
    function automatic t_chk chk33(input logic [DATA_W:0] v);
        t_chk c;
        c.res = v[DATA_W-1:0];
        c.st  = ST_OK;
        if (!v[DATA_W] && v[DATA_W-1]) begin
            c.res = '0;
            c.st  = ST_OVF;
        end else if (v[DATA_W] && !v[DATA_W-1]) begin
            c.res = '0;
            c.st  = ST_UDF;
        end
        return c;
    endfunction

endpackage

// ----- design/checked_integer_alu.sv -----
// top level of the checked signed 32-bit alu with overflow status
//
// channel   direction  signals
// request   in         i_start, o_busy, i_operation, i_operand_a, i_operand_b
// result    out        o_done, o_result_value, o_status
// config    in         i_cfg_we, i_cfg_idx, i_cfg_wdata
//
// one request per cycle, and each request yields one result on o_done
// the pipeline depth is set by the 32-stage divider, one quotient bit per stage
// all operations share that depth so results leave in request order
// reset clears the valid bits and sets true code 1, false code 0
// o_busy is always low and the receiver cannot stall o_done
module checked_integer_alu
    import cia_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  logic [4:0]        i_operation,
    input  logic [DATA_W-1:0] i_operand_a,
    input  logic [DATA_W-1:0] i_operand_b,
    output logic              o_done,
    output logic [DATA_W-1:0] o_result_value,
    output logic [1:0]        o_status,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [DATA_W-1:0] i_cfg_wdata
);

    typedef struct packed {
        t_op               op;
        logic [DATA_W-1:0] res;
        t_status           st;
        logic              qsign;
        logic              rsign;
        logic              dz;
    } t_stage;

    logic [DATA_W-1:0] r_true_code;
    logic [DATA_W-1:0] r_false_code;

    logic              r_vld_s0;
    t_op               r_op_s0;
    logic [DATA_W-1:0] r_a_s0;
    logic [DATA_W-1:0] r_b_s0;

    logic                r_vld_a;
    t_stage              r_sa;
    logic [2*DATA_W-1:0] r_prod;
    logic [DATA_W-1:0]   r_mag_a;
    logic [DATA_W-1:0]   r_mag_b;

    logic              r_vld_b;
    t_stage            r_sb;

    logic [DLY_STAGES-1:0] r_vld_dly;
    t_stage                r_dly [DLY_STAGES];

    logic              r_out_vld;
    logic [DATA_W-1:0] r_out_res;
    t_status           r_out_st;

    t_stage              n_sa;
    t_stage              n_sb;
    logic [DATA_W-1:0]   n_out_res;
    t_status             n_out_st;
    logic [DATA_W-1:0]   w_quot;
    logic [DATA_W-1:0]   w_rem;
    logic [DATA_W-1:0]   w_q_signed;
    logic [DATA_W-1:0]   w_r_signed;
    t_chk                w_chk;
    t_stage              w_last;

    assign o_busy = 1'b0;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_true_code  <= DATA_W'(1);
            r_false_code <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_TRUE:  r_true_code  <= i_cfg_wdata;
                CFG_FALSE: r_false_code <= i_cfg_wdata;
                default:   r_true_code  <= r_true_code;
            endcase
        end
    end

    // valid bits through the pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_s0  <= 1'b0;
            r_vld_a   <= 1'b0;
            r_vld_b   <= 1'b0;
            r_vld_dly <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_vld_s0  <= i_start && !o_busy;
            r_vld_a   <= r_vld_s0;
            r_vld_b   <= r_vld_a;
            r_vld_dly <= {r_vld_dly[DLY_STAGES-2:0], r_vld_b};
            r_out_vld <= r_vld_dly[DLY_STAGES-1];
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        r_op_s0 <= t_op'(i_operation);
        r_a_s0  <= i_operand_a;
        r_b_s0  <= i_operand_b;
    end

    // stage a: simple operations, multiply and divider operand prep
    always_comb begin
        n_sa       = '0;
        n_sa.op    = r_op_s0;
        n_sa.st    = ST_OK;
        n_sa.qsign = r_a_s0[DATA_W-1] ^ r_b_s0[DATA_W-1];
        n_sa.rsign = r_a_s0[DATA_W-1];
        n_sa.dz    = (r_b_s0 == '0);
        unique case (r_op_s0)
            OP_ADD: begin
                {n_sa.res, n_sa.st} = chk33({r_a_s0[DATA_W-1], r_a_s0}
                                            + {r_b_s0[DATA_W-1], r_b_s0});
            end
            OP_SUB: begin
                {n_sa.res, n_sa.st} = chk33({r_a_s0[DATA_W-1], r_a_s0}
                                            - {r_b_s0[DATA_W-1], r_b_s0});
            end
            OP_NEG: begin
                {n_sa.res, n_sa.st} = chk33((DATA_W+1)'(0)
                                            - {r_a_s0[DATA_W-1], r_a_s0});
            end
            OP_XOR:   n_sa.res = r_a_s0 ^ r_b_s0;
            OP_AND:   n_sa.res = r_a_s0 & r_b_s0;
            OP_OR:    n_sa.res = r_a_s0 | r_b_s0;
            OP_SHL:   n_sa.res = r_a_s0 << r_b_s0[4:0];
            OP_SHR:   n_sa.res = DATA_W'($signed(r_a_s0) >>> r_b_s0[4:0]);
            OP_EQ: begin
                n_sa.res = (r_a_s0 == r_b_s0) ? r_true_code : r_false_code;
            end
            OP_NE: begin
                n_sa.res = (r_a_s0 != r_b_s0) ? r_true_code : r_false_code;
            end
            OP_LT: begin
                n_sa.res = ($signed(r_a_s0) < $signed(r_b_s0))
                           ? r_true_code : r_false_code;
            end
            OP_LE: begin
                n_sa.res = ($signed(r_a_s0) <= $signed(r_b_s0))
                           ? r_true_code : r_false_code;
            end
            OP_GT: begin
                n_sa.res = ($signed(r_a_s0) > $signed(r_b_s0))
                           ? r_true_code : r_false_code;
            end
            OP_GE: begin
                n_sa.res = ($signed(r_a_s0) >= $signed(r_b_s0))
                           ? r_true_code : r_false_code;
            end
            OP_PLUS:  n_sa.res = r_a_s0;
            OP_NOT: begin
                n_sa.res = (r_a_s0 == r_false_code) ? r_true_code : r_false_code;
            end
            OP_COMPL: n_sa.res = ~r_a_s0;
            default:  n_sa.res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_sa    <= n_sa;
        r_prod  <= $signed(r_a_s0) * $signed(r_b_s0);
        r_mag_a <= r_a_s0[DATA_W-1] ? (DATA_W'(0) - r_a_s0) : r_a_s0;
        r_mag_b <= r_b_s0[DATA_W-1] ? (DATA_W'(0) - r_b_s0) : r_b_s0;
    end

    // stage b: product range check
    always_comb begin
        n_sb = r_sa;
        if (r_sa.op == OP_MUL) begin
            n_sb.res = r_prod[DATA_W-1:0];
            n_sb.st  = ST_OK;
            if (!r_prod[2*DATA_W-1] && (|r_prod[2*DATA_W-2:DATA_W-1])) begin
                n_sb.res = '0;
                n_sb.st  = ST_OVF;
            end else if (r_prod[2*DATA_W-1] && !(&r_prod[2*DATA_W-2:DATA_W-1])) begin
                n_sb.res = '0;
                n_sb.st  = ST_UDF;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sb <= n_sb;
    end

    // delay line matching the divider depth
    always_ff @(posedge i_clk) begin
        r_dly[0] <= r_sb;
        for (int k = 1; k < DLY_STAGES; k++) begin
            r_dly[k] <= r_dly[k-1];
        end
    end

    cia_div u_div (
        .i_clk      (i_clk),
        .i_dividend (r_mag_a),
        .i_divisor  (r_mag_b),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    // final stage: sign fixup and divide status
    assign w_last     = r_dly[DLY_STAGES-1];
    assign w_q_signed = w_last.qsign ? (DATA_W'(0) - w_quot) : w_quot;
    assign w_r_signed = w_last.rsign ? (DATA_W'(0) - w_rem) : w_rem;

    always_comb begin
        w_chk.res = w_last.res;
        w_chk.st  = w_last.st;
        if (w_last.op == OP_DIV) begin
            if (w_last.dz) begin
                w_chk.res = '0;
                w_chk.st  = ST_DIV_ZERO;
            end else if (!w_last.qsign && w_quot[DATA_W-1]) begin
                w_chk.res = '0;
                w_chk.st  = ST_OVF;
            end else begin
                w_chk.res = w_q_signed;
                w_chk.st  = ST_OK;
            end
        end else if (w_last.op == OP_MOD) begin
            if (w_last.dz) begin
                w_chk.res = '0;
                w_chk.st  = ST_DIV_ZERO;
            end else begin
                w_chk.res = w_r_signed;
                w_chk.st  = ST_OK;
            end
        end
        n_out_res = w_chk.res;
        n_out_st  = w_chk.st;
    end

    always_ff @(posedge i_clk) begin
        r_out_res <= n_out_res;
        r_out_st  <= n_out_st;
    end

    assign o_done         = r_out_vld;
    assign o_result_value = r_out_res;
    assign o_status       = r_out_st;

    // any error status forces a zero value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_status != ST_OK) |-> (o_result_value == '0))
        else $error("error status with nonzero result");

    // each result traces back to a matching earlier request
    a_done_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start, RSP_LAT))
        else $error("result without matching request");

    // divide by zero status only for a zero divisor
    a_dz_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_status == ST_DIV_ZERO) |-> $past(i_operand_b == '0, RSP_LAT))
        else $error("divide by zero status with nonzero divisor");

endmodule

// ----- design/cia_div.sv -----
// pipelined unsigned restoring divider, one quotient bit per stage
module cia_div
    import cia_pkg::*;
(
    input  logic              i_clk,
    input  logic [DATA_W-1:0] i_dividend,
    input  logic [DATA_W-1:0] i_divisor,
    output logic [DATA_W-1:0] o_quot,
    output logic [DATA_W-1:0] o_rem
);

    logic [DATA_W-1:0] r_rem [DIV_STAGES];
    logic [DATA_W-1:0] r_quo [DIV_STAGES];
    logic [DATA_W-1:0] r_dsr [DIV_STAGES-1];

    genvar k;
    for (k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic [DATA_W-1:0] w_rem;
        logic [DATA_W-1:0] w_quo;
        logic [DATA_W-1:0] w_dsr;
        logic [DATA_W:0]   w_trial;
        logic [DATA_W:0]   w_diff;

        // stage inputs
        if (k == 0) begin : g_first
            assign w_rem = '0;
            assign w_quo = i_dividend;
            assign w_dsr = i_divisor;
        end else begin : g_next
            assign w_rem = r_rem[k-1];
            assign w_quo = r_quo[k-1];
            assign w_dsr = r_dsr[k-1];
        end

        // shift in next dividend bit and try the subtract
        assign w_trial = {w_rem, w_quo[DATA_W-1]};
        assign w_diff  = w_trial - {1'b0, w_dsr};

        always_ff @(posedge i_clk) begin
            if (!w_diff[DATA_W]) begin
                r_rem[k] <= w_diff[DATA_W-1:0];
                r_quo[k] <= {w_quo[DATA_W-2:0], 1'b1};
            end else begin
                r_rem[k] <= w_trial[DATA_W-1:0];
                r_quo[k] <= {w_quo[DATA_W-2:0], 1'b0};
            end
        end

        // divisor travels along, not needed after the last stage
        if (k < DIV_STAGES - 1) begin : g_dsr
            always_ff @(posedge i_clk) begin
                r_dsr[k] <= w_dsr;
            end
        end
    end

    assign o_quot = r_quo[DIV_STAGES-1];
    assign o_rem  = r_rem[DIV_STAGES-1];

endmodule

// ----- verif/tb_top.sv -----
// self-checking testbench for the checked integer alu: directed table, then random requests
`timescale 1ns / 1ps

module tb_top;
    import cia_pkg::*;

    localparam int  CLK_HALF    = 10;
    localparam int  RAND_ITEMS  = 125;
    localparam int  STALL_LIMIT = 4 * RSP_LAT + 200;
    localparam logic [4:0] OP_SPARE_LO = 5'd20;
    localparam logic [4:0] OP_SPARE_HI = 5'd31;
    localparam logic [31:0] MAX_POS = 32'h7fff_ffff;
    localparam logic [31:0] MAX_NEG = 32'h8000_0000;
    localparam logic [31:0] MINUS_1 = 32'hffff_ffff;

    typedef struct packed {
        logic [31:0] value;
        t_status     st;
    } alu_res_t;

    typedef struct {
        logic [4:0]  op;
        logic [31:0] a;
        logic [31:0] b;
        bit          fixed;
        alu_res_t    res;
    } req_row_t;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_start;
    logic              o_busy;
    logic [4:0]        i_operation;
    logic [DATA_W-1:0] i_operand_a;
    logic [DATA_W-1:0] i_operand_b;
    logic              o_done;
    logic [DATA_W-1:0] o_result_value;
    logic [1:0]        o_status;
    logic              i_cfg_we;
    logic              i_cfg_idx;
    logic [DATA_W-1:0] i_cfg_wdata;

    logic [31:0] true_val;
    logic [31:0] false_val;
    alu_res_t    pending_q[$];
    int          errors;
    int          n_req;
    int          n_res;
    int          idle_cycles;
    int          idle_pct;

    checked_integer_alu uut (.*);

    // clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // keep a wide result within signed 32 bits or flag it
    function automatic alu_res_t fit32(longint wide);
        alu_res_t r;
        r.value = wide[31:0];
        r.st    = ST_OK;
        if (wide > longint'(32'sh7fff_ffff)) begin
            r = '{value: '0, st: ST_OVF};
        end else if (wide < -longint'(64'sh8000_0000)) begin
            r = '{value: '0, st: ST_UDF};
        end
        return r;
    endfunction

    // expected value and status of one request
    function automatic alu_res_t predict_alu(logic [4:0] op, logic [31:0] a, logic [31:0] b);
        longint   sa;
        longint   sb;
        alu_res_t r;
        sa = $signed(a);
        sb = $signed(b);
        r  = '{value: '0, st: ST_OK};
        case (op)
            OP_ADD:   r = fit32(sa + sb);
            OP_SUB:   r = fit32(sa - sb);
            OP_MUL:   r = fit32(sa * sb);
            OP_DIV:   r = (sb == 0) ? alu_res_t'{'0, ST_DIV_ZERO} : fit32(sa / sb);
            OP_MOD:   r = (sb == 0) ? alu_res_t'{'0, ST_DIV_ZERO} : fit32(sa % sb);
            OP_XOR:   r.value = a ^ b;
            OP_AND:   r.value = a & b;
            OP_OR:    r.value = a | b;
            OP_SHL:   r.value = a << b[4:0];
            OP_SHR:   r.value = $signed(a) >>> b[4:0];
            OP_EQ:    r.value = (sa == sb) ? true_val : false_val;
            OP_NE:    r.value = (sa != sb) ? true_val : false_val;
            OP_LT:    r.value = (sa <  sb) ? true_val : false_val;
            OP_LE:    r.value = (sa <= sb) ? true_val : false_val;
            OP_GT:    r.value = (sa >  sb) ? true_val : false_val;
            OP_GE:    r.value = (sa >= sb) ? true_val : false_val;
            OP_PLUS:  r.value = a;
            OP_NEG:   r = fit32(-sa);
            OP_NOT:   r.value = (a == false_val) ? true_val : false_val;
            OP_COMPL: r.value = ~a;
            default:  r = '{value: '0, st: ST_OK};
        endcase
        return r;
    endfunction

    // operand with bias toward edges, small values and the false code
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0:       return MAX_POS;
            1:       return MAX_NEG;
            2:       return MINUS_1;
            3:       return '0;
            4:       return 32'($urandom_range(0, 70000));
            5:       return -32'($urandom_range(0, 70000));
            6:       return false_val;
            default: return $urandom;
        endcase
    endfunction

    // drive one request and hold it until accepted
    task automatic send_req(logic [4:0] op, logic [31:0] a, logic [31:0] b,
                            bit fixed, alu_res_t fixed_res);
        alu_res_t exp_res;
        int       gap;
        i_start     <= 1'b1;
        i_operation <= op;
        i_operand_a <= a;
        i_operand_b <= b;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        exp_res = fixed ? fixed_res : predict_alu(op, a, b);
        pending_q.push_back(exp_res);
        n_req++;
        gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_start <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
    endtask

    // write both codes while nothing is in flight
    task automatic set_codes(logic [31:0] t_code, logic [31:0] f_code);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_TRUE;
        i_cfg_wdata <= t_code;
        @(posedge i_clk);
        i_cfg_idx   <= CFG_FALSE;
        i_cfg_wdata <= f_code;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        true_val    = t_code;
        false_val   = f_code;
    endtask

    // result checker and stall watchdog
    always @(posedge i_clk) begin
        alu_res_t exp_res;
        if (i_rst_n && o_done) begin
            n_res <= n_res + 1;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result value=%h status=%0d",
                         $time, o_result_value, o_status);
                errors++;
            end else begin
                exp_res = pending_q.pop_front();
                if (o_result_value !== exp_res.value) begin
                    $display("%0t: value mismatch expected %h actual %h",
                             $time, exp_res.value, o_result_value);
                    errors++;
                end
                if (o_status !== exp_res.st) begin
                    $display("%0t: status mismatch expected %0d actual %0d",
                             $time, exp_res.st, o_status);
                    errors++;
                end
            end
        end
        if (!i_rst_n || o_done || (i_start && !o_busy)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // stimulus
    initial begin
        req_row_t rows[$];
        int       pcts[4];
        logic [31:0] codes[4][2];
        logic [4:0]  op;
        rows = '{
            '{OP_ADD,  MAX_POS, 32'd1,    1, '{32'd0, ST_OVF}},
            '{OP_ADD,  MAX_NEG, MINUS_1,  1, '{32'd0, ST_UDF}},
            '{OP_SUB,  MAX_NEG, 32'd1,    1, '{32'd0, ST_UDF}},
            '{OP_SUB,  MAX_POS, MINUS_1,  1, '{32'd0, ST_OVF}},
            '{OP_MUL,  32'h1_0000, 32'h1_0000, 1, '{32'd0, ST_OVF}},
            '{OP_MUL,  32'h1_0000, 32'hffff_0000, 1, '{32'd0, ST_UDF}},
            '{OP_MUL,  MAX_NEG, MINUS_1,  1, '{32'd0, ST_OVF}},
            '{OP_DIV,  MAX_NEG, MINUS_1,  1, '{32'd0, ST_OVF}},
            '{OP_MOD,  MAX_NEG, MINUS_1,  1, '{32'd0, ST_OK}},
            '{OP_DIV,  32'd5,   32'd0,    1, '{32'd0, ST_DIV_ZERO}},
            '{OP_MOD,  32'd5,   32'd0,    1, '{32'd0, ST_DIV_ZERO}},
            '{OP_DIV,  -32'd7,  32'd2,    0, '{32'd0, ST_OK}},
            '{OP_MOD,  -32'd7,  32'd2,    0, '{32'd0, ST_OK}},
            '{OP_XOR,  MAX_POS, 32'h5555_aaaa, 0, '{32'd0, ST_OK}},
            '{OP_AND,  MINUS_1, 32'h1234_5678, 0, '{32'd0, ST_OK}},
            '{OP_OR,   MAX_NEG, 32'h0f0f_0f0f, 0, '{32'd0, ST_OK}},
            '{OP_SHL,  32'd1,   32'h3f,   1, '{MAX_NEG, ST_OK}},
            '{OP_SHR,  MAX_NEG, 32'd31,   1, '{MINUS_1, ST_OK}},
            '{OP_EQ,   MINUS_1, MINUS_1,  1, '{32'd1, ST_OK}},
            '{OP_NE,   MINUS_1, MINUS_1,  1, '{32'd0, ST_OK}},
            '{OP_LT,   MAX_NEG, MAX_POS,  1, '{32'd1, ST_OK}},
            '{OP_LE,   MAX_POS, MAX_NEG,  1, '{32'd0, ST_OK}},
            '{OP_GT,   32'd3,   MINUS_1,  0, '{32'd0, ST_OK}},
            '{OP_GE,   MINUS_1, MINUS_1,  0, '{32'd0, ST_OK}},
            '{OP_PLUS, MAX_NEG, 32'd0,    1, '{MAX_NEG, ST_OK}},
            '{OP_NEG,  MAX_NEG, 32'd0,    1, '{32'd0, ST_OVF}},
            '{OP_NOT,  32'd0,   MINUS_1,  1, '{32'd1, ST_OK}},
            '{OP_COMPL, 32'h0f0f_f0f0, 32'd0, 0, '{32'd0, ST_OK}},
            '{OP_SPARE_HI, MINUS_1, MINUS_1, 1, '{32'd0, ST_OK}}
        };
        pcts  = '{8, 70, 0, 8};
        codes = '{'{MAX_POS, MAX_NEG}, '{MAX_NEG, MAX_POS},
                  '{MINUS_1, 32'd0}, '{32'h1357_9bdf, 32'hfedc_ba98}};

        i_rst_n     <= 1'b0;
        i_start     <= 1'b0;
        i_operation <= '0;
        i_operand_a <= '0;
        i_operand_b <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= CFG_TRUE;
        i_cfg_wdata <= '0;
        true_val    = 32'd1;
        false_val   = 32'd0;
        errors      = 0;
        n_req       = 0;
        n_res       = 0;
        idle_cycles = 0;
        idle_pct    = 8;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table with reset codes
        foreach (rows[i]) begin
            send_req(rows[i].op, rows[i].a, rows[i].b, rows[i].fixed, rows[i].res);
        end

        // random phases, each under new codes and idle pattern
        for (int ph = 0; ph < 4; ph++) begin
            set_codes(codes[ph][0], codes[ph][1]);
            idle_pct = pcts[ph];
            for (int k = 0; k < RAND_ITEMS; k++) begin
                if ($urandom_range(0, 15) == 0)
                    op = 5'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
                else
                    op = 5'($urandom_range(OP_ADD, OP_COMPL));
                send_req(op, pick_operand(), pick_operand(), 0, '{32'd0, ST_OK});
            end
        end

        wait_drained();
        repeat (RSP_LAT + 8) @(posedge i_clk);
        $display("covered %0d requests (%0d results) over reset and four code settings",
                 n_req, n_res);
        $display("idle mixes of 8, 70 and 0 percent, all ops plus unused codes");
        if (errors == 0 && pending_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ----- files.f -----
design/cia_pkg.sv
design/cia_div.sv
design/checked_integer_alu.sv
verif/tb_top.sv
